[sv/fcc_pkg.sv]
// Package for the table-copy consistency checker.
// Holds the transaction types, request and status codes and register indexes.
// No dependencies; every other file of the block uses it.
package fcc_pkg;

	// Request codes of an input transaction.
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CHECK = 2'd2;
	localparam logic [1:0] REQ_SCAN  = 2'd3;

	// Status codes of a result transaction.
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_BAD_NOREPAIR = 3'd1;
	localparam logic [2:0] ST_BAD_ALL      = 3'd2;
	localparam logic [2:0] ST_LOOP         = 3'd3;
	localparam logic [2:0] ST_RANGE        = 3'd4;
	localparam logic [2:0] ST_TOO_MANY     = 3'd5;
	localparam logic [2:0] ST_ADDR         = 3'd6;

	// Configuration register indexes.
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_REPAIR_ENABLE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COPIES_IN_USE   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CLUSTERS_IN_USE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_END_MARKER      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BAD_MARKER      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED_MARKER   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MISMATCH_LIMIT  = 3'd6;

	// Register reset values.
	localparam logic [2:0]  RST_COPIES   = 3'd2;
	localparam logic [12:0] RST_CLUSTERS = 13'd4096;
	localparam logic [31:0] RST_END      = 32'hFFFF_FFFF;
	localparam logic [31:0] RST_BAD      = 32'hFFFF_FFF7;
	localparam logic [31:0] RST_UNUSED   = 32'h0000_0000;
	localparam logic [15:0] RST_LIMIT    = 16'd16;

	// Input transaction.
	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  copy_index;
		logic [11:0] cluster_index;
		logic [31:0] entry_value;
		logic [31:0] chain_head;
	} req_item_t;

	// Result transaction.
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] read_value;
		logic [16:0] mismatch_count;
		logic [12:0] free_count;
		logic [14:0] repair_count;
	} rsp_item_t;

	// Effective configuration, with the copy and cluster counts saturated.
	typedef struct packed {
		logic        repair_enable;
		logic [2:0]  ncopies;
		logic [12:0] nclusters;
		logic [31:0] end_marker;
		logic [31:0] bad_marker;
		logic [31:0] unused_marker;
		logic [15:0] mismatch_limit;
	} cfg_t;

endpackage

[sv/fcc_cfg_regs.sv]
// Configuration registers of the table-copy consistency checker.
// Takes register writes and presents the saturated working configuration.
// Depends on fcc_pkg.
module fcc_cfg_regs #(
	parameter int MAX_CLUSTERS = 4096,
	parameter int MAX_COPIES   = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fcc_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [31:0]                   cfg_wdata,
	output fcc_pkg::cfg_t                 cfg
);

	logic        repair_q;
	logic [2:0]  copies_q;
	logic [12:0] clusters_q;
	logic [31:0] end_q;
	logic [31:0] bad_q;
	logic [31:0] unused_q;
	logic [15:0] limit_q;

	// Register file, written one register per write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repair_q   <= 1'b0;
			copies_q   <= fcc_pkg::RST_COPIES;
			clusters_q <= fcc_pkg::RST_CLUSTERS;
			end_q      <= fcc_pkg::RST_END;
			bad_q      <= fcc_pkg::RST_BAD;
			unused_q   <= fcc_pkg::RST_UNUSED;
			limit_q    <= fcc_pkg::RST_LIMIT;
		end else if (cfg_we) begin
			case (cfg_addr)
				fcc_pkg::REG_REPAIR_ENABLE:   repair_q   <= cfg_wdata[0];
				fcc_pkg::REG_COPIES_IN_USE:   copies_q   <= cfg_wdata[2:0];
				fcc_pkg::REG_CLUSTERS_IN_USE: clusters_q <= cfg_wdata[12:0];
				fcc_pkg::REG_END_MARKER:      end_q      <= cfg_wdata;
				fcc_pkg::REG_BAD_MARKER:      bad_q      <= cfg_wdata;
				fcc_pkg::REG_UNUSED_MARKER:   unused_q   <= cfg_wdata;
				fcc_pkg::REG_MISMATCH_LIMIT:  limit_q    <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Saturate the counts into the range the storage supports.
	always_comb begin
		cfg.repair_enable  = repair_q;
		cfg.end_marker     = end_q;
		cfg.bad_marker     = bad_q;
		cfg.unused_marker  = unused_q;
		cfg.mismatch_limit = limit_q;
		if (copies_q == 3'd0) begin
			cfg.ncopies = 3'd1;
		end else if ({1'b0, copies_q} > 4'(MAX_COPIES)) begin
			cfg.ncopies = 3'(MAX_COPIES);
		end else begin
			cfg.ncopies = copies_q;
		end
		if (clusters_q == 13'd0) begin
			cfg.nclusters = 13'd1;
		end else if ({4'd0, clusters_q} > 17'(MAX_CLUSTERS)) begin
			cfg.nclusters = 13'(MAX_CLUSTERS);
		end else begin
			cfg.nclusters = clusters_q;
		end
	end

endmodule

[sv/fat_chain_consistency_checker_top.sv]
// Top level of the table-copy consistency checker.
// Holds the table memory and the request sequencer; uses fcc_pkg and fcc_cfg_regs.
//
// All table copies live in one synchronous memory with one write and one
// registered read port; every request is served by a sequencer that reads,
// compares and writes back through that port, one request at a time. A chain
// check reads every copy of each cluster it visits, one memory read per copy,
// and follows the primary entry until the walk reaches the end marker. A scan
// reads every copy of each entry until the mismatch limit is passed and only
// the primary entry after that. A finished result sits in an output register,
// so the next request is taken as soon as the sequencer is free; a request
// that finishes while an earlier result is still waiting there holds its
// result until the output register empties. The memory has no reset; table
// entries must be written before they are read, checked or scanned.
module fat_chain_consistency_checker_top #(
	parameter int MAX_CLUSTERS = 4096,
	parameter int MAX_COPIES   = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fcc_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [31:0]                   cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  fcc_pkg::req_item_t            req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output fcc_pkg::rsp_item_t            rsp_data
);

	localparam int DEPTH = MAX_COPIES * MAX_CLUSTERS;
	localparam int MAW   = $clog2(DEPTH);
	localparam int AW    = $clog2(MAX_CLUSTERS);

	// Sequencer states.
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_RD       = 3'd1;
	localparam logic [2:0] S_CHK_HEAD = 3'd2;
	localparam logic [2:0] S_CHK_PRIM = 3'd3;
	localparam logic [2:0] S_CHK_BAK  = 3'd4;
	localparam logic [2:0] S_SCN_PRIM = 3'd5;
	localparam logic [2:0] S_SCN_BAK  = 3'd6;
	localparam logic [2:0] S_FIN      = 3'd7;

	fcc_pkg::cfg_t cfg;

	fcc_cfg_regs #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.MAX_COPIES  (MAX_COPIES)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	// Flat memory address of an entry of a copy.
	function automatic logic [MAW-1:0] mem_addr(input logic [2:0] c, input logic [31:0] k);
		return MAW'(MAW'(c) * MAW'(MAX_CLUSTERS)) + MAW'(k[AW-1:0]);
	endfunction

	logic [2:0]         state_q, state_d;
	logic [31:0]        cur_q, cur_d;
	logic [13:0]        step_q, step_d;
	logic [12:0]        k_q, k_d;
	logic [2:0]         copy_q, copy_d;
	logic [31:0]        p_q, p_d;
	logic [16:0]        mm_q, mm_d;
	logic [12:0]        free_q, free_d;
	logic [14:0]        rep_q, rep_d;
	logic               fail_q, fail_d;
	fcc_pkg::rsp_item_t res_q, res_d;
	fcc_pkg::rsp_item_t rsp_q, rsp_d;
	logic               rsp_valid_q, rsp_valid_d;

	logic [31:0]        mem_q [DEPTH];
	logic [31:0]        rdata_q;
	logic               mem_we, mem_re;
	logic [MAW-1:0]     mem_waddr, mem_raddr;
	logic [31:0]        mem_wdata;

	logic               fin_valid;
	fcc_pkg::rsp_item_t fin_res;
	logic               out_free;

	assign req_ready = (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Table memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	// Sequencer: read, compare and write back the copies of each entry, one request at a time.
	always_comb begin
		logic        addr_ok;
		logic        tail_go;
		logic        adv_go;
		logic [31:0] pn;
		logic        fail_n;
		logic [16:0] mm_n;
		logic [12:0] free_n;
		logic [14:0] rep_n;

		addr_ok = ({1'b0, req_data.copy_index} < cfg.ncopies) &&
			({1'b0, req_data.cluster_index} < cfg.nclusters);
		tail_go = 1'b0;
		adv_go  = 1'b0;
		pn      = p_q;
		fail_n  = fail_q;
		mm_n    = mm_q;
		free_n  = free_q;
		rep_n   = rep_q;

		state_d   = state_q;
		cur_d     = cur_q;
		step_d    = step_q;
		k_d       = k_q;
		copy_d    = copy_q;
		p_d       = p_q;
		mm_d      = mm_q;
		free_d    = free_q;
		rep_d     = rep_q;
		fail_d    = fail_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = mem_addr(3'd0, 32'd0);
		mem_raddr = mem_addr(3'd0, 32'd0);
		mem_wdata = req_data.entry_value;
		fin_valid = 1'b0;
		fin_res   = '0;
		fin_res.status = fcc_pkg::ST_OK;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req_data.req_type)
						fcc_pkg::REQ_WRITE: begin
							fin_valid = 1'b1;
							if (addr_ok) begin
								mem_we    = 1'b1;
								mem_waddr = mem_addr({1'b0, req_data.copy_index},
									32'(req_data.cluster_index));
							end else begin
								fin_res.status = fcc_pkg::ST_ADDR;
							end
						end
						fcc_pkg::REQ_READ: begin
							if (addr_ok) begin
								mem_re    = 1'b1;
								mem_raddr = mem_addr({1'b0, req_data.copy_index},
									32'(req_data.cluster_index));
								state_d   = S_RD;
							end else begin
								fin_valid      = 1'b1;
								fin_res.status = fcc_pkg::ST_ADDR;
							end
						end
						fcc_pkg::REQ_CHECK: begin
							cur_d   = req_data.chain_head;
							step_d  = '0;
							rep_d   = '0;
							state_d = S_CHK_HEAD;
						end
						default: begin
							k_d       = '0;
							mm_d      = '0;
							free_d    = '0;
							fail_d    = 1'b0;
							mem_re    = 1'b1;
							mem_raddr = mem_addr(3'd0, 32'd0);
							state_d   = S_SCN_PRIM;
						end
					endcase
				end
			end
			S_RD: begin
				fin_valid          = 1'b1;
				fin_res.read_value = rdata_q;
			end
			S_CHK_HEAD: begin
				fin_res.repair_count = rep_q;
				if (cur_q == cfg.end_marker) begin
					fin_valid = 1'b1;
				end else if (cur_q >= {19'd0, cfg.nclusters}) begin
					fin_valid      = 1'b1;
					fin_res.status = fcc_pkg::ST_RANGE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = mem_addr(3'd0, cur_q);
					copy_d    = 3'd1;
					state_d   = S_CHK_PRIM;
				end
			end
			S_CHK_PRIM: begin
				p_d = rdata_q;
				pn  = rdata_q;
				if (cfg.ncopies > 3'd1) begin
					mem_re    = 1'b1;
					mem_raddr = mem_addr(3'd1, cur_q);
					state_d   = S_CHK_BAK;
				end else begin
					tail_go = 1'b1;
				end
			end
			S_CHK_BAK: begin
				// A mismatch involving the bad marker is repaired from the good side when repair is enabled.
				if (p_q != rdata_q && (p_q == cfg.bad_marker || rdata_q == cfg.bad_marker)) begin
					if (!cfg.repair_enable) begin
						fin_valid            = 1'b1;
						fin_res.status       = fcc_pkg::ST_BAD_NOREPAIR;
						fin_res.repair_count = rep_q;
					end else begin
						mem_we = 1'b1;
						if (p_q != cfg.bad_marker) begin
							mem_waddr = mem_addr(copy_q, cur_q);
							mem_wdata = p_q;
						end else begin
							mem_waddr = mem_addr(3'd0, cur_q);
							mem_wdata = rdata_q;
							pn        = rdata_q;
						end
						rep_n = rep_q + 15'd1;
						rep_d = rep_n;
					end
				end
				if (!fin_valid) begin
					p_d = pn;
					if (({1'b0, copy_q} + 4'd1) < {1'b0, cfg.ncopies}) begin
						mem_re    = 1'b1;
						mem_raddr = mem_addr(copy_q + 3'd1, cur_q);
						copy_d    = copy_q + 3'd1;
					end else begin
						tail_go = 1'b1;
					end
				end
			end
			S_SCN_PRIM: begin
				p_d = rdata_q;
				if (rdata_q == cfg.unused_marker) begin
					free_n = free_q + 13'd1;
				end
				free_d = free_n;
				if (!fail_q && cfg.ncopies > 3'd1) begin
					mem_re    = 1'b1;
					mem_raddr = mem_addr(3'd1, 32'(k_q));
					copy_d    = 3'd1;
					state_d   = S_SCN_BAK;
				end else begin
					adv_go = 1'b1;
				end
			end
			S_SCN_BAK: begin
				// The mismatch count stops at the first count above the limit.
				if (rdata_q != p_q) begin
					mm_n = mm_q + 17'd1;
					if (mm_n > {1'b0, cfg.mismatch_limit}) begin
						fail_n = 1'b1;
					end
				end
				mm_d   = mm_n;
				fail_d = fail_n;
				if (!fail_n && (({1'b0, copy_q} + 4'd1) < {1'b0, cfg.ncopies})) begin
					mem_re    = 1'b1;
					mem_raddr = mem_addr(copy_q + 3'd1, 32'(k_q));
					copy_d    = copy_q + 3'd1;
				end else begin
					adv_go = 1'b1;
				end
			end
			S_FIN: begin
				fin_valid = 1'b1;
				fin_res   = res_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// End of one cluster of a chain check: follow the primary entry.
		if (tail_go) begin
			fin_res.repair_count = rep_n;
			if (pn == cfg.bad_marker) begin
				fin_valid      = 1'b1;
				fin_res.status = fcc_pkg::ST_BAD_ALL;
			end else begin
				cur_d  = pn;
				step_d = step_q + 14'd1;
				if (step_d > {1'b0, cfg.nclusters}) begin
					fin_valid      = 1'b1;
					fin_res.status = fcc_pkg::ST_LOOP;
				end else begin
					state_d = S_CHK_HEAD;
				end
			end
		end

		// End of one entry of a scan: move to the next entry or finish.
		if (adv_go) begin
			if (({1'b0, k_q} + 14'd1) == {1'b0, cfg.nclusters}) begin
				fin_valid              = 1'b1;
				fin_res.status         = fail_n ? fcc_pkg::ST_TOO_MANY : fcc_pkg::ST_OK;
				fin_res.mismatch_count = mm_n;
				fin_res.free_count     = free_n;
			end else begin
				k_d       = k_q + 13'd1;
				mem_re    = 1'b1;
				mem_raddr = mem_addr(3'd0, 32'(k_d));
				state_d   = S_SCN_PRIM;
			end
		end

		// Hand the result to the output register, or hold it while that is full.
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		if (fin_valid) begin
			if (out_free) begin
				rsp_d       = fin_res;
				rsp_valid_d = 1'b1;
				state_d     = S_IDLE;
			end else begin
				res_d   = fin_res;
				state_d = S_FIN;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			cur_q       <= '0;
			step_q      <= '0;
			k_q         <= '0;
			copy_q      <= '0;
			mm_q        <= '0;
			free_q      <= '0;
			rep_q       <= '0;
			fail_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
			cur_q       <= cur_d;
			step_q      <= step_d;
			k_q         <= k_d;
			copy_q      <= copy_d;
			mm_q        <= mm_d;
			free_q      <= free_d;
			rep_q       <= rep_d;
			fail_q      <= fail_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		p_q   <= p_d;
		res_q <= res_d;
		rsp_q <= rsp_d;
	end

	// A held result only exists while the output register is occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> rsp_valid_q)
		else $error("held result without a pending output transaction");

	// Backup copy walks stay within the copies in use and never touch the primary.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK_BAK || state_q == S_SCN_BAK) |->
		(copy_q != 3'd0 && copy_q < cfg.ncopies))
		else $error("backup copy counter out of range");

	// A chain walk never runs past the loop bound.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK_HEAD) |-> (step_q <= {1'b0, cfg.nclusters}))
		else $error("chain step counter beyond cluster count");

	// The scan mismatch count stops one above the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCN_PRIM || state_q == S_SCN_BAK) |->
		(mm_q <= ({1'b0, cfg.mismatch_limit} + 17'd1)))
		else $error("scan mismatch count ran past the limit");

	// A transaction taken from the requester always leaves the idle state or yields a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != S_IDLE || rsp_valid_q))
		else $error("accepted request produced no work and no result");

endmodule

[tb/fat_chain_consistency_checker_top_tb.sv]
// Self-checking testbench for the checker top level: a directed table, then random phases.
// Depends on fcc_pkg and the checker RTL; expected results come from a predictor in this file.
`timescale 1ns / 1ps

module fat_chain_consistency_checker_top_tb;

	localparam int MAX_CLUSTERS = 4096;
	localparam int MAX_COPIES   = 4;
	localparam int STALL_LIMIT  = 100000;

	// One row of the directed table: a register write or a request transaction.
	typedef struct packed {
		bit                            is_cfg;
		logic [fcc_pkg::REG_IDX_W-1:0] reg_idx;
		logic [31:0]                   reg_val;
		fcc_pkg::req_item_t            rq;
		bit                            typed;
		fcc_pkg::rsp_item_t            ans;
	} dir_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [fcc_pkg::REG_IDX_W-1:0] cfg_addr;
	logic [31:0]                   cfg_wdata;
	logic                          req_valid;
	logic                          req_ready;
	fcc_pkg::req_item_t            req_data;
	logic                          rsp_valid;
	logic                          rsp_ready = 1'b0;
	fcc_pkg::rsp_item_t            rsp_data;

	// Shadow of the table copies and of the configuration registers.
	logic [31:0] shadow_fat [0:MAX_COPIES*MAX_CLUSTERS-1];
	logic        sh_repair   = 1'b0;
	logic [2:0]  sh_copies   = fcc_pkg::RST_COPIES;
	logic [12:0] sh_clusters = fcc_pkg::RST_CLUSTERS;
	logic [31:0] sh_end      = fcc_pkg::RST_END;
	logic [31:0] sh_bad      = fcc_pkg::RST_BAD;
	logic [31:0] sh_unused   = fcc_pkg::RST_UNUSED;
	logic [15:0] sh_limit    = fcc_pkg::RST_LIMIT;

	fcc_pkg::rsp_item_t due_answers [$];
	dir_row_t           dir_rows [$];
	int                 mismatches = 0;
	int                 rsp_count = 0;
	int                 idle_cycles = 0;
	int                 send_idle_pct = 0;
	int                 rsp_stall_pct = 0;

	fat_chain_consistency_checker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	always #2 clk = ~clk;

	// Saturated copy and cluster counts, as the block applies them.
	function automatic int unsigned live_copies();
		if (sh_copies == 0) return 1;
		if (sh_copies > MAX_COPIES) return MAX_COPIES;
		return sh_copies;
	endfunction

	function automatic int unsigned live_clusters();
		if (sh_clusters == 0) return 1;
		if (sh_clusters > MAX_CLUSTERS) return MAX_CLUSTERS;
		return sh_clusters;
	endfunction

	// Follow a chain through the primary copy, repairing bad-marker mismatches when repair is enabled.
	function automatic fcc_pkg::rsp_item_t walk_chain(input logic [31:0] start);
		fcc_pkg::rsp_item_t ans;
		logic [31:0]        cur, p, b;
		int unsigned        ncp, ncl, steps, reps;
		bit                 stop;
		ans = '0;
		ncp = live_copies();
		ncl = live_clusters();
		cur = start;
		steps = 0;
		reps = 0;
		stop = 1'b0;
		while (!stop && cur != sh_end) begin
			if (cur >= ncl) begin
				ans.status = fcc_pkg::ST_RANGE;
				stop = 1'b1;
			end else begin
				for (int c = 1; c < ncp && !stop; c++) begin
					p = shadow_fat[cur];
					b = shadow_fat[c*MAX_CLUSTERS + cur];
					if (p != b && (p == sh_bad || b == sh_bad)) begin
						if (!sh_repair) begin
							ans.status = fcc_pkg::ST_BAD_NOREPAIR;
							stop = 1'b1;
						end else begin
							if (p != sh_bad) shadow_fat[c*MAX_CLUSTERS + cur] = p;
							else shadow_fat[cur] = b;
							reps++;
						end
					end
				end
				if (!stop) begin
					if (shadow_fat[cur] == sh_bad) begin
						ans.status = fcc_pkg::ST_BAD_ALL;
						stop = 1'b1;
					end else begin
						cur = shadow_fat[cur];
						steps++;
						if (steps > ncl) begin
							ans.status = fcc_pkg::ST_LOOP;
							stop = 1'b1;
						end
					end
				end
			end
		end
		ans.repair_count = reps[14:0];
		return ans;
	endfunction

	// Count backup entries that differ from the primary, and free primary entries.
	function automatic fcc_pkg::rsp_item_t scan_copies();
		fcc_pkg::rsp_item_t ans;
		logic [31:0]        p;
		int unsigned        ncp, ncl, mm, fr;
		ans = '0;
		ncp = live_copies();
		ncl = live_clusters();
		mm = 0;
		fr = 0;
		for (int k = 0; k < ncl; k++) begin
			p = shadow_fat[k];
			if (p == sh_unused) fr++;
			for (int c = 1; c < ncp && ans.status == fcc_pkg::ST_OK; c++) begin
				if (p != shadow_fat[c*MAX_CLUSTERS + k]) begin
					mm++;
					if (mm > sh_limit) ans.status = fcc_pkg::ST_TOO_MANY;
				end
			end
		end
		ans.mismatch_count = mm[16:0];
		ans.free_count = fr[12:0];
		return ans;
	endfunction

	// Apply one request to the shadow state and return the result it produces.
	function automatic fcc_pkg::rsp_item_t serve_request(input fcc_pkg::req_item_t rq);
		fcc_pkg::rsp_item_t ans;
		int                 slot;
		ans = '0;
		slot = int'(rq.copy_index) * MAX_CLUSTERS + int'(rq.cluster_index);
		case (rq.req_type)
			fcc_pkg::REQ_WRITE, fcc_pkg::REQ_READ: begin
				if (rq.copy_index >= live_copies() || rq.cluster_index >= live_clusters())
					ans.status = fcc_pkg::ST_ADDR;
				else if (rq.req_type == fcc_pkg::REQ_WRITE)
					shadow_fat[slot] = rq.entry_value;
				else
					ans.read_value = shadow_fat[slot];
			end
			fcc_pkg::REQ_CHECK: begin
				ans = walk_chain(rq.chain_head);
			end
			default: begin
				ans = scan_copies();
			end
		endcase
		return ans;
	endfunction

	function automatic fcc_pkg::req_item_t mk_req(input logic [1:0] t, input logic [1:0] c,
			input logic [11:0] k, input logic [31:0] v, input logic [31:0] s);
		fcc_pkg::req_item_t rq;
		rq.req_type = t;
		rq.copy_index = c;
		rq.cluster_index = k;
		rq.entry_value = v;
		rq.chain_head = s;
		return rq;
	endfunction

	function automatic void row_cfg(input logic [fcc_pkg::REG_IDX_W-1:0] idx,
			input logic [31:0] val);
		dir_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic void row_req(input fcc_pkg::req_item_t rq);
		dir_row_t row;
		row = '0;
		row.rq = rq;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic void row_typed(input fcc_pkg::req_item_t rq, input logic [2:0] st,
			input logic [31:0] rd);
		dir_row_t row;
		row = '0;
		row.rq = rq;
		row.typed = 1'b1;
		row.ans.status = st;
		row.ans.read_value = rd;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	// Entry value that tends to build chains: links, end, bad and free markers.
	function automatic logic [31:0] chain_value();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 50) return 32'($urandom_range(live_clusters() - 1));
		if (pick < 65) return sh_end;
		if (pick < 75) return sh_bad;
		if (pick < 85) return sh_unused;
		return $urandom();
	endfunction

	// Backup entry value: mostly a copy of the primary, sometimes bad or unrelated.
	function automatic logic [31:0] backup_value(input logic [11:0] k);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 80) return shadow_fat[k];
		if (pick < 92) return sh_bad;
		return chain_value();
	endfunction

	function automatic fcc_pkg::req_item_t random_request(input int scan_pct);
		fcc_pkg::req_item_t rq;
		int unsigned        ncp, ncl, pick;
		ncp = live_copies();
		ncl = live_clusters();
		rq.entry_value = $urandom();
		rq.chain_head = $urandom();
		pick = $urandom_range(99);
		if (pick < scan_pct) begin
			rq.req_type = fcc_pkg::REQ_SCAN;
		end else begin
			pick = $urandom_range(99);
			rq.req_type = (pick < 45) ? fcc_pkg::REQ_WRITE :
				(pick < 70) ? fcc_pkg::REQ_READ : fcc_pkg::REQ_CHECK;
		end
		rq.copy_index = ($urandom_range(99) < 85) ? 2'($urandom_range(ncp - 1))
			: 2'($urandom_range(3));
		rq.cluster_index = ($urandom_range(99) < 90) ? 12'($urandom_range(ncl - 1))
			: 12'($urandom_range(4095));
		if (rq.req_type == fcc_pkg::REQ_WRITE && rq.copy_index < ncp && rq.cluster_index < ncl)
			rq.entry_value = (rq.copy_index == 0) ? chain_value() : backup_value(rq.cluster_index);
		if (rq.req_type == fcc_pkg::REQ_CHECK) begin
			pick = $urandom_range(99);
			if (pick < 70) rq.chain_head = 32'($urandom_range(ncl - 1));
			else if (pick < 80) rq.chain_head = sh_end;
		end
		return rq;
	endfunction

	// Present one request transaction and record its expected result once accepted.
	task automatic send_req(input fcc_pkg::req_item_t it, input bit typed,
			input fcc_pkg::rsp_item_t ans);
		fcc_pkg::rsp_item_t got;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req_data <= it;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		got = serve_request(it);
		due_answers.insert(due_answers.size(), typed ? ans : got);
	endtask

	// Hold off the request side until every expected result has come back.
	task automatic wait_drain();
		req_valid <= 1'b0;
		while (due_answers.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Drive one register write; the caller lowers the write enable after a burst.
	task automatic cfg_write(input logic [fcc_pkg::REG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			fcc_pkg::REG_REPAIR_ENABLE:   sh_repair = val[0];
			fcc_pkg::REG_COPIES_IN_USE:   sh_copies = val[2:0];
			fcc_pkg::REG_CLUSTERS_IN_USE: sh_clusters = val[12:0];
			fcc_pkg::REG_END_MARKER:      sh_end = val;
			fcc_pkg::REG_BAD_MARKER:      sh_bad = val;
			fcc_pkg::REG_UNUSED_MARKER:   sh_unused = val;
			fcc_pkg::REG_MISMATCH_LIMIT:  sh_limit = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Write every entry in use, primary first so that backups can copy it.
	task automatic fill_tables();
		int unsigned ncp, ncl;
		logic [31:0] v;
		ncp = live_copies();
		ncl = live_clusters();
		for (int k = 0; k < ncl; k++) begin
			for (int c = 0; c < ncp; c++) begin
				v = (c == 0) ? chain_value() : backup_value(12'(k));
				send_req(mk_req(fcc_pkg::REQ_WRITE, 2'(c), 12'(k), v, $urandom()), 1'b0, '0);
			end
		end
	endtask

	// One random phase: configure, load the tables, then run random requests.
	task automatic run_phase(input logic rep, input logic [2:0] cps, input logic [12:0] cls,
			input logic [31:0] endm, input logic [31:0] badm, input logic [31:0] freem,
			input logic [15:0] lim, input int snd, input int stl, input int n,
			input int scan_pct);
		wait_drain();
		send_idle_pct = snd;
		rsp_stall_pct = stl;
		cfg_write(fcc_pkg::REG_REPAIR_ENABLE, {31'd0, rep});
		cfg_write(fcc_pkg::REG_COPIES_IN_USE, {29'd0, cps});
		cfg_write(fcc_pkg::REG_CLUSTERS_IN_USE, {19'd0, cls});
		cfg_write(fcc_pkg::REG_END_MARKER, endm);
		cfg_write(fcc_pkg::REG_BAD_MARKER, badm);
		cfg_write(fcc_pkg::REG_UNUSED_MARKER, freem);
		cfg_write(fcc_pkg::REG_MISMATCH_LIMIT, {16'd0, lim});
		cfg_we <= 1'b0;
		fill_tables();
		for (int i = 0; i < n; i++) begin
			// Midway, let the block run completely dry once.
			if (i == n / 2) wait_drain();
			send_req(random_request(scan_pct), 1'b0, '0);
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at result %0d: %s", rsp_count, what);
		mismatches++;
	endtask

	// Receiver side: random stalls on the result channel.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// Compare each accepted result transaction with the oldest expectation.
	always @(posedge clk) begin : result_check
		fcc_pkg::rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (due_answers.size() == 0) begin
				report_mismatch("result with nothing outstanding");
			end else begin
				want = due_answers.pop_front();
				if (rsp_data.status !== want.status)
					report_mismatch($sformatf("status %0d, wanted %0d",
						rsp_data.status, want.status));
				if (rsp_data.read_value !== want.read_value)
					report_mismatch($sformatf("read_value %h, wanted %h",
						rsp_data.read_value, want.read_value));
				if (rsp_data.mismatch_count !== want.mismatch_count)
					report_mismatch($sformatf("mismatch_count %0d, wanted %0d",
						rsp_data.mismatch_count, want.mismatch_count));
				if (rsp_data.free_count !== want.free_count)
					report_mismatch($sformatf("free_count %0d, wanted %0d",
						rsp_data.free_count, want.free_count));
				if (rsp_data.repair_count !== want.repair_count)
					report_mismatch($sformatf("repair_count %0d, wanted %0d",
						rsp_data.repair_count, want.repair_count));
			end
			rsp_count++;
		end
	end

	// Watchdog: too long without any transaction on either channel ends the run.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		bit cfg_open;
		cfg_open = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		req_valid <= 1'b0;
		req_data <= '0;

		// Reset configuration: bad addresses, trivial chains, and one written entry pair.
		row_typed(mk_req(fcc_pkg::REQ_WRITE, 2'd2, 12'd0, 32'h0, 32'h0), fcc_pkg::ST_ADDR, '0);
		row_typed(mk_req(fcc_pkg::REQ_READ, 2'd3, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
			fcc_pkg::ST_ADDR, '0);
		row_typed(mk_req(fcc_pkg::REQ_CHECK, 2'd0, 12'd0, 32'h0, fcc_pkg::RST_END),
			fcc_pkg::ST_OK, '0);
		row_typed(mk_req(fcc_pkg::REQ_CHECK, 2'd3, 12'd4095, 32'h0, 32'd4096),
			fcc_pkg::ST_RANGE, '0);
		row_typed(mk_req(fcc_pkg::REQ_CHECK, 2'd0, 12'd0, 32'h0, 32'hFFFF_FFFE),
			fcc_pkg::ST_RANGE, '0);
		row_typed(mk_req(fcc_pkg::REQ_WRITE, 2'd0, 12'd4095, 32'hFFFF_FFFF, 32'h0),
			fcc_pkg::ST_OK, '0);
		row_typed(mk_req(fcc_pkg::REQ_WRITE, 2'd1, 12'd4095, 32'hFFFF_FFFF, 32'h0),
			fcc_pkg::ST_OK, '0);
		row_typed(mk_req(fcc_pkg::REQ_READ, 2'd1, 12'd4095, 32'h0, 32'h0),
			fcc_pkg::ST_OK, 32'hFFFF_FFFF);
		row_req(mk_req(fcc_pkg::REQ_CHECK, 2'd0, 12'd0, 32'h0, 32'd4095));
		// A cluster count above the table size saturates to the full table.
		row_cfg(fcc_pkg::REG_CLUSTERS_IN_USE, 32'd8191);
		row_typed(mk_req(fcc_pkg::REQ_CHECK, 2'd0, 12'd0, 32'h0, 32'd4096),
			fcc_pkg::ST_RANGE, '0);
		row_typed(mk_req(fcc_pkg::REQ_READ, 2'd0, 12'd4095, 32'h0, 32'h0),
			fcc_pkg::ST_OK, 32'hFFFF_FFFF);
		// Two clusters, zero tolerance; chain 0 -> 1 -> end with a bad backup at 1.
		row_cfg(fcc_pkg::REG_CLUSTERS_IN_USE, 32'd2);
		row_cfg(fcc_pkg::REG_MISMATCH_LIMIT, 32'd0);
		row_req(mk_req(fcc_pkg::REQ_WRITE, 2'd0, 12'd0, 32'd1, 32'h0));
		row_req(mk_req(fcc_pkg::REQ_WRITE, 2'd0, 12'd1, fcc_pkg::RST_END, 32'h0));
		row_req(mk_req(fcc_pkg::REQ_WRITE, 2'd1, 12'd0, 32'd1, 32'h0));
		row_req(mk_req(fcc_pkg::REQ_WRITE, 2'd1, 12'd1, fcc_pkg::RST_BAD, 32'h0));
		row_typed(mk_req(fcc_pkg::REQ_WRITE, 2'd0, 12'd2, 32'h0, 32'h0), fcc_pkg::ST_ADDR, '0);
		row_req(mk_req(fcc_pkg::REQ_CHECK, 2'd0, 12'd0, 32'h0, 32'd0));
		row_req(mk_req(fcc_pkg::REQ_SCAN, 2'd0, 12'd0, 32'h0, 32'h0));
		// With repair: fix the backup, then bad in all copies, a loop, a bad primary.
		row_cfg(fcc_pkg::REG_REPAIR_ENABLE, 32'd1);
		row_req(mk_req(fcc_pkg::REQ_CHECK, 2'd0, 12'd0, 32'h0, 32'd0));
		row_req(mk_req(fcc_pkg::REQ_SCAN, 2'd0, 12'd0, 32'h0, 32'h0));
		row_req(mk_req(fcc_pkg::REQ_WRITE, 2'd0, 12'd0, fcc_pkg::RST_BAD, 32'h0));
		row_req(mk_req(fcc_pkg::REQ_WRITE, 2'd1, 12'd0, fcc_pkg::RST_BAD, 32'h0));
		row_req(mk_req(fcc_pkg::REQ_CHECK, 2'd0, 12'd0, 32'h0, 32'd0));
		row_req(mk_req(fcc_pkg::REQ_WRITE, 2'd0, 12'd0, 32'h0, 32'h0));
		row_req(mk_req(fcc_pkg::REQ_CHECK, 2'd0, 12'd0, 32'h0, 32'd0));
		row_req(mk_req(fcc_pkg::REQ_WRITE, 2'd0, 12'd1, fcc_pkg::RST_BAD, 32'h0));
		row_req(mk_req(fcc_pkg::REQ_CHECK, 2'd0, 12'd0, 32'h0, 32'd1));
		row_req(mk_req(fcc_pkg::REQ_SCAN, 2'd3, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, with light idling on both sides.
		send_idle_pct = 29;
		rsp_stall_pct = 29;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				if (!cfg_open) wait_drain();
				cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_we <= 1'b0;
					cfg_open = 1'b0;
				end
				send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].ans);
			end
		end

		// Random phases over several settings, register extremes and saturation included.
		run_phase(1'b1, 3'd4, 13'd16, 32'hFFFF_FFFF, 32'hFFFF_FFF7, 32'h0, 16'hFFFF,
			0, 0, 100, 10);
		run_phase(1'b0, 3'd3, 13'd8, 32'h0, 32'hFFFF_FFFF, 32'd5, 16'd2,
			56, 0, 90, 10);
		run_phase(1'b1, 3'd0, 13'd1, 32'd7, 32'd3, 32'hFFFF_FFFF, 16'd0,
			0, 56, 60, 10);
		run_phase(1'b1, 3'd7, 13'd32, $urandom(), $urandom(), $urandom(), 16'd5,
			29, 29, 100, 10);
		run_phase(1'b0, 3'd2, 13'd64, fcc_pkg::RST_END, fcc_pkg::RST_BAD, fcc_pkg::RST_UNUSED,
			16'd10, 0, 0, 100, 10);
		run_phase(1'b1, 3'd1, 13'd24, 32'hFFFF_FFFE, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF,
			0, 0, 40, 3);
		run_phase(1'b1, 3'd5, 13'd0, 32'd1, 32'd0, 32'd2, 16'd1,
			29, 29, 60, 10);
		run_phase(1'b0, 3'd4, 13'd12, $urandom(), $urandom(), $urandom(), 16'd1,
			56, 0, 96, 10);

		wait_drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
